// ----- hdl/rclp_pkg.sv -----
// ----------------------------------------------------------------------------
// Relay command line parser package
// Shared types, codes and keyword tables.
// ----------------------------------------------------------------------------
package rclp_pkg;

   localparam int KwCount = 9;
   localparam int SlotCount = 4;
   localparam int QueueDepth = 2;

   typedef enum logic [3:0] {
      KIND_INVALID = 4'd0, KIND_PING = 4'd1, KIND_VERSION = 4'd2, KIND_STATUS = 4'd3,
      KIND_ALLON = 4'd4, KIND_HELP = 4'd5, KIND_RESET = 4'd6, KIND_ON = 4'd7,
      KIND_OFF = 4'd8, KIND_PULSE = 4'd9
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE = 3'd0, ERR_SYNTAX = 3'd1, ERR_TRANSACTION = 3'd2, ERR_CHANNEL = 3'd3,
      ERR_TIME = 3'd4, ERR_UNKNOWN = 3'd5
   } err_type;

   typedef enum logic [1:0] {
      CSR_RELAY_COUNT = 2'd0, CSR_MIN_SECONDS = 2'd1, CSR_MAX_SECONDS = 2'd2,
      CSR_DEFAULT_OFF = 2'd3
   } csr_type;

   // Snapshot of one finished line, handed from front to back.
   typedef struct packed {
      logic [2:0]  token_count;
      logic        too_many;
      logic [3:0]  kw_pos;
      logic [8:0]  kw_cand;
      logic [SlotCount-1:0][31:0] value;
      logic [SlotCount-1:0][1:0]  flags;
   } line_type;

   typedef struct packed {
      logic [3:0]  command_kind;
      logic [7:0]  channel;
      logic [31:0] seconds;
      logic [31:0] session;
      logic [31:0] transaction;
      logic [2:0]  error_code;
   } result_type;

   function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [3:0] p);
      logic [7:0] s [0:8][0:6];
      s[0] = '{"P","I","N","G",8'h0,8'h0,8'h0};
      s[1] = '{"V","E","R","S","I","O","N"};
      s[2] = '{"S","T","A","T","U","S",8'h0};
      s[3] = '{"A","L","L","O","N",8'h0,8'h0};
      s[4] = '{"H","E","L","P",8'h0,8'h0,8'h0};
      s[5] = '{"R","E","S","E","T",8'h0,8'h0};
      s[6] = '{"O","N",8'h0,8'h0,8'h0,8'h0,8'h0};
      s[7] = '{"O","F","F",8'h0,8'h0,8'h0,8'h0};
      s[8] = '{"P","U","L","S","E",8'h0,8'h0};
      if (k > 4'd8 || p > 4'd6) return 8'h0;
      return s[k][p[2:0]];
   endfunction

   function automatic logic [3:0] kw_len(input logic [3:0] k);
      case (k)
         4'd0: return 4'd4;
         4'd1: return 4'd7;
         4'd2: return 4'd6;
         4'd3: return 4'd5;
         4'd4: return 4'd4;
         4'd5: return 4'd5;
         4'd6: return 4'd2;
         4'd7: return 4'd3;
         4'd8: return 4'd5;
         default: return 4'd0;
      endcase
   endfunction

endpackage

// ----- hdl/rclp_front.sv -----
// ----------------------------------------------------------------------------
// Relay command line parser front
// Tokenizes words, matches the keyword and accumulates numbers per line.
// ----------------------------------------------------------------------------
module rclp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [7:0]          in_char,
   input  logic                in_last,
   output logic                line_valid,
   input  logic                line_ready,
   output rclp_pkg::line_type  line_data
);
   import rclp_pkg::*;

   line_type cur_ff, cur_in;
   logic     inside_ff, inside_in;
   logic     stopped_ff, stopped_in;
   line_type fresh;
   logic [7:0] c;
   logic [1:0] slot;
   logic [35:0] prod;
   logic take;

   assign in_ready   = line_ready;
   assign take       = in_valid && in_ready;
   assign line_valid = take && in_last;

   always_comb begin
      fresh = '0;
      fresh.kw_cand = '1;
      c = (in_char >= "a" && in_char <= "z") ? in_char - 8'd32 : in_char;
      cur_in = cur_ff;
      inside_in = inside_ff;
      stopped_in = stopped_ff;
      slot = 2'(cur_ff.token_count - 3'd2);
      prod = '0;
      if (!stopped_ff) begin
         if (c == 8'd0) begin
            stopped_in = 1'b1;
            inside_in = 1'b0;
         end else if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) begin
            inside_in = 1'b0;
         end else begin
            // open a new token
            if (!inside_ff) begin
               if (cur_ff.token_count >= 3'd5) cur_in.too_many = 1'b1;
               else begin
                  cur_in.token_count = cur_ff.token_count + 3'd1;
                  inside_in = 1'b1;
               end
            end
            slot = 2'(cur_in.token_count - 3'd2);
            if (!cur_in.too_many) begin
               if (cur_in.token_count == 3'd1) begin
                  for (int k = 0; k < KwCount; k++) begin
                     if (cur_ff.kw_pos >= kw_len(4'(k)) || kw_char(4'(k), cur_ff.kw_pos) != c)
                        cur_in.kw_cand[k] = 1'b0;
                  end
                  if (cur_ff.kw_pos != 4'd15) cur_in.kw_pos = cur_ff.kw_pos + 4'd1;
               end else if (c < "0" || c > "9") begin
                  cur_in.flags[slot][0] = 1'b1;
               end else if (!cur_ff.flags[slot][1]) begin
                  prod = {cur_ff.value[slot], 3'b0} + {2'b0, cur_ff.value[slot], 1'b0}
                         + 36'(c - "0");
                  if (prod[35:32] != 4'd0) cur_in.flags[slot][1] = 1'b1;
                  else cur_in.value[slot] = prod[31:0];
               end
            end
         end
      end
      line_data = cur_in;
      if (take && in_last) begin
         cur_in = fresh;
         inside_in = 1'b0;
         stopped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= fresh;
         inside_ff <= 1'b0;
         stopped_ff <= 1'b0;
      end else if (take) begin
         cur_ff <= cur_in;
         inside_ff <= inside_in;
         stopped_ff <= stopped_in;
      end
   end
endmodule

// ----- hdl/rclp_queue.sv -----
// ----------------------------------------------------------------------------
// Relay command line parser queue
// Two-entry queue of finished lines between front and back.
// ----------------------------------------------------------------------------
module rclp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_valid,
   output logic               wr_ready,
   input  rclp_pkg::line_type wr_data,
   output logic               rd_valid,
   input  logic               rd_ready,
   output rclp_pkg::line_type rd_data
);
   import rclp_pkg::*;

   line_type mem_ff [QueueDepth];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic wr, rd;

   assign wr_ready = cnt_ff != 2'(QueueDepth);
   assign rd_valid = cnt_ff != 2'd0;
   assign rd_data  = mem_ff[rp_ff];
   assign wr = wr_valid && wr_ready;
   assign rd = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (wr) wp_ff <= ~wp_ff;
         if (rd) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(wr) - 2'(rd);
      end
   end
endmodule

// ----- hdl/rclp_back.sv -----
// ----------------------------------------------------------------------------
// Relay command line parser back
// Decodes a finished line into a result and holds it in an output register.
// ----------------------------------------------------------------------------
module rclp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           relay_count,
   input  logic [31:0]          min_seconds,
   input  logic [31:0]          max_seconds,
   input  logic [31:0]          default_off,
   input  logic                 line_valid,
   output logic                 line_ready,
   input  rclp_pkg::line_type   line_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output rclp_pkg::result_type out_data
);
   import rclp_pkg::*;

   logic       valid_ff;
   result_type res_ff, res_in;
   kind_type   kind;
   logic [3:0] kind_num;
   logic [SlotCount-1:0] ok, ch_ok, tm_ok;
   logic [2:0] tc;

   assign line_ready = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign out_data   = res_ff;

   always_comb begin
      tc = line_data.token_count;
      for (int s = 0; s < SlotCount; s++) begin
         ok[s] = line_data.flags[s] == 2'd0;
         ch_ok[s] = ok[s] && line_data.value[s] != 32'd0
                    && line_data.value[s] <= {24'd0, relay_count};
         tm_ok[s] = ok[s] && line_data.value[s] >= min_seconds
                    && line_data.value[s] <= max_seconds;
      end
      kind_num = 4'd0;
      for (int k = KwCount - 1; k >= 0; k--) begin
         if (line_data.kw_cand[k] && line_data.kw_pos == kw_len(4'(k))) kind_num = 4'(k + 1);
      end
      kind = kind_type'(kind_num);
      res_in = '0;
      if (line_data.too_many || tc == 3'd0) res_in.error_code = ERR_SYNTAX;
      else if (kind == KIND_INVALID) res_in.error_code = ERR_UNKNOWN;
      else if (kind_num <= 4'd5) begin
         if (tc != 3'd1) res_in.error_code = ERR_SYNTAX;
         else res_in.command_kind = kind;
      end else if (kind == KIND_RESET) begin
         if (tc != 3'd5) res_in.error_code = ERR_SYNTAX;
         else if (!ok[0] || line_data.value[0] == 32'd0 || !ok[1] || line_data.value[1] == 32'd0)
            res_in.error_code = ERR_TRANSACTION;
         else if (!ch_ok[2]) res_in.error_code = ERR_CHANNEL;
         else if (!tm_ok[3]) res_in.error_code = ERR_TIME;
         else begin
            res_in.command_kind = kind;
            res_in.channel = line_data.value[2][7:0];
            res_in.seconds = line_data.value[3];
            res_in.session = line_data.value[0];
            res_in.transaction = line_data.value[1];
         end
      end else if (tc < 3'd2 || tc > ((kind == KIND_ON) ? 3'd2 : 3'd3)) begin
         res_in.error_code = ERR_SYNTAX;
      end else if (!ch_ok[0]) res_in.error_code = ERR_CHANNEL;
      else if (kind == KIND_ON) begin
         res_in.command_kind = kind;
         res_in.channel = line_data.value[0][7:0];
      end else if (tc == 3'd2) begin
         if (kind == KIND_PULSE) res_in.error_code = ERR_SYNTAX;
         else begin
            res_in.command_kind = kind;
            res_in.channel = line_data.value[0][7:0];
            res_in.seconds = default_off;
         end
      end else if (!tm_ok[1]) res_in.error_code = ERR_TIME;
      else begin
         res_in.command_kind = kind;
         res_in.channel = line_data.value[0][7:0];
         res_in.seconds = line_data.value[1];
      end
   end

   always_ff @(posedge clock) begin
      if (line_valid && line_ready) res_ff <= res_in;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (line_ready) valid_ff <= line_valid;
   end
endmodule

// ----- hdl/relay_command_line_parser_core.sv -----
// ----------------------------------------------------------------------------
// Relay command line parser core
// Parses a command line one character per word and gives one decoded result.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req_    | in  | tdata = character[7:0], tlast = last
//  rsp_    | out | tdata = kind, channel, seconds, session, transaction, error
//  csr_    | in  | index[1:0], data[31:0]
//
// One character word per cycle while the queue has room; the front does all
// per-character work in the cycle that accepts the word. The back decodes a
// line into an output register. A two-line queue between them lets a stalled
// rsp_ side leave the front running until the queue fills. Reset is
// synchronous, active high, and restores the registers to 8, 1, 3600 and 5.
module relay_command_line_parser_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // character[7:0]
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // command_kind[3:0], channel[11:4], seconds[43:12], session[75:44],
   // transaction[107:76], error_code[110:108], zero fill
   output logic [111:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);
   import rclp_pkg::*;

   logic [7:0]  relay_count_ff;
   logic [31:0] min_sec_ff, max_sec_ff, def_off_ff;
   logic        f_valid, f_ready, q_valid, q_ready;
   line_type    f_data, q_data;
   result_type  res;

   assign csr_ready = 1'b1;

   // hold configuration until written
   always_ff @(posedge clock) begin
      if (reset) begin
         relay_count_ff <= 8'd8;
         min_sec_ff <= 32'd1;
         max_sec_ff <= 32'd3600;
         def_off_ff <= 32'd5;
      end else if (csr_valid) begin
         case (csr_type'(csr_index))
            CSR_RELAY_COUNT: relay_count_ff <= csr_data[7:0];
            CSR_MIN_SECONDS: min_sec_ff <= csr_data;
            CSR_MAX_SECONDS: max_sec_ff <= csr_data;
            CSR_DEFAULT_OFF: def_off_ff <= csr_data;
            default: ;
         endcase
      end
   end

   rclp_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_char(req_tdata), .in_last(req_tlast),
      .line_valid(f_valid), .line_ready(f_ready), .line_data(f_data)
   );

   rclp_queue u_queue (
      .clock, .reset,
      .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
      .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
   );

   rclp_back u_back (
      .clock, .reset,
      .relay_count(relay_count_ff), .min_seconds(min_sec_ff),
      .max_seconds(max_sec_ff), .default_off(def_off_ff),
      .line_valid(q_valid), .line_ready(q_ready), .line_data(q_data),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(res)
   );

   assign rsp_tdata = {1'b0, res.error_code, res.transaction, res.session,
                       res.seconds, res.channel, res.command_kind};
endmodule

// ----- hdl/rclp_checker.sv -----
// ----------------------------------------------------------------------------
// Relay command line parser checker
// Port-level checks on results and handshakes.
// ----------------------------------------------------------------------------
module rclp_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [111:0] rsp_tdata,
   input logic         csr_ready
);
   import rclp_pkg::*;

   a_err_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[110:108] != ERR_NONE |-> rsp_tdata[107:0] == '0)
      else $error("error result carries data");
   a_kind_err: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[3:0] == KIND_INVALID) == (rsp_tdata[110:108] != ERR_NONE))
      else $error("kind and error disagree");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");
   a_csr: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("config port stalled");
endmodule

bind relay_command_line_parser_core rclp_checker u_rclp_checker (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_ready
);

// ----- bench/relay_command_line_parser_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relay command line parser core testbench
// Streams directed and random command lines into the parser one character
// word at a time, predicts each decoded line result in a scoreboard and
// checks every result word field by field, with random stalls on both sides.
// ----------------------------------------------------------------------------
module relay_command_line_parser_core_test;
   import rclp_pkg::*;

   typedef struct {
      logic [3:0]  kind;
      logic [7:0]  channel;
      logic [31:0] seconds;
      logic [31:0] session;
      logic [31:0] transaction;
      logic [2:0]  error;
   } decode_t;

   // Line decoder and store of pending decoded lines.
   class line_scoreboard;
      logic [7:0]  relay_count = 8;
      logic [31:0] min_sec = 1, max_sec = 3600, off_sec = 5;
      int unsigned tokens;
      bit          overflow_tokens, in_token, stopped;
      int unsigned kw_pos;
      logic [8:0]  kw_cand;
      logic [31:0] value [4];
      logic [1:0]  flags [4];
      decode_t     pending [$];
      int          errors;

      function new();
         clear_line();
      endfunction

      function void clear_line();
         tokens = 0; overflow_tokens = 0; in_token = 0; stopped = 0;
         kw_pos = 0; kw_cand = '1;
         for (int i = 0; i < 4; i++) begin
            value[i] = 0; flags[i] = 0;
         end
      endfunction

      function void set_reg(csr_type idx, logic [31:0] d);
         case (idx)
            CSR_RELAY_COUNT: relay_count = d[7:0];
            CSR_MIN_SECONDS: min_sec = d;
            CSR_MAX_SECONDS: max_sec = d;
            CSR_DEFAULT_OFF: off_sec = d;
         endcase
      endfunction

      function bit num_good(int s);
         return flags[s] == 0;
      endfunction

      function bit chan_good(int s);
         return num_good(s) && value[s] >= 1 && value[s] <= relay_count;
      endfunction

      function bit time_good(int s);
         return num_good(s) && value[s] >= min_sec && value[s] <= max_sec;
      endfunction

      function void take(logic [7:0] c);
         int s;
         logic [35:0] acc;
         if (c >= "a" && c <= "z") c = c - 8'd32;
         if (!in_token) begin
            if (tokens >= 5) begin
               overflow_tokens = 1;
               return;
            end
            tokens++;
            in_token = 1;
         end
         if (overflow_tokens) return;
         if (tokens == 1) begin
            for (int k = 0; k < 9; k++)
               if (kw_pos >= kw_len(4'(k)) || kw_char(4'(k), 4'(kw_pos)) != c) kw_cand[k] = 0;
            if (kw_pos < 15) kw_pos++;
         end else begin
            s = (tokens - 2) & 3;
            if (c < "0" || c > "9") flags[s][0] = 1;
            else if (!flags[s][1]) begin
               acc = value[s] * 36'd10 + (c - "0");
               if (acc > 36'hFFFFFFFF) flags[s][1] = 1;
               else value[s] = acc[31:0];
            end
         end
      endfunction

      function decode_t decode();
         decode_t r;
         kind_type kind;
         r = '{default: 0};
         kind = KIND_INVALID;
         if (overflow_tokens || tokens == 0) begin r.error = ERR_SYNTAX; return r; end
         for (int k = 0; k < 9; k++)
            if (kw_cand[k] && kw_pos == kw_len(4'(k))) begin
               kind = kind_type'(k + 1);
               break;
            end
         if (kind == KIND_INVALID) begin r.error = ERR_UNKNOWN; return r; end
         if (kind <= KIND_HELP) begin
            if (tokens != 1) r.error = ERR_SYNTAX;
            else r.kind = kind;
            return r;
         end
         if (kind == KIND_RESET) begin
            if (tokens != 5) r.error = ERR_SYNTAX;
            else if (!num_good(0) || value[0] == 0 || !num_good(1) || value[1] == 0)
               r.error = ERR_TRANSACTION;
            else if (!chan_good(2)) r.error = ERR_CHANNEL;
            else if (!time_good(3)) r.error = ERR_TIME;
            else begin
               r.kind = KIND_RESET; r.channel = value[2][7:0]; r.seconds = value[3];
               r.session = value[0]; r.transaction = value[1];
            end
            return r;
         end
         if (tokens < 2 || tokens > (kind == KIND_ON ? 2 : 3)) begin
            r.error = ERR_SYNTAX; return r;
         end
         if (!chan_good(0)) begin r.error = ERR_CHANNEL; return r; end
         if (kind != KIND_ON) begin
            if (tokens == 2) begin
               if (kind == KIND_PULSE) begin r.error = ERR_SYNTAX; return r; end
               r.seconds = off_sec;
            end else begin
               if (!time_good(1)) begin r.error = ERR_TIME; return r; end
               r.seconds = value[1];
            end
         end
         r.kind = kind; r.channel = value[0][7:0];
         return r;
      endfunction

      // Note one accepted character word.
      function void note_char(logic [7:0] c, logic lst);
         if (!stopped) begin
            if (c == 0) begin stopped = 1; in_token = 0; end
            else if (c == 32 || (c >= 9 && c <= 13)) in_token = 0;
            else take(c);
         end
         if (lst) begin
            pending.push_back(decode());
            clear_line();
         end
      endfunction

      // Check one accepted result word against the oldest pending line.
      function void check(logic [111:0] d);
         decode_t e;
         if (pending.size() == 0) begin
            $error("unexpected result word %h", d);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (d[3:0] !== e.kind) begin
            $error("command_kind exp %0d got %0d", e.kind, d[3:0]); errors++; end
         if (d[11:4] !== e.channel) begin
            $error("channel exp %0d got %0d", e.channel, d[11:4]); errors++; end
         if (d[43:12] !== e.seconds) begin
            $error("seconds exp %0d got %0d", e.seconds, d[43:12]); errors++; end
         if (d[75:44] !== e.session) begin
            $error("session exp %0d got %0d", e.session, d[75:44]); errors++; end
         if (d[107:76] !== e.transaction) begin
            $error("transaction exp %0d got %0d", e.transaction, d[107:76]); errors++; end
         if (d[110:108] !== e.error) begin
            $error("error_code exp %0d got %0d", e.error, d[110:108]); errors++; end
         if (d[111] !== 1'b0) begin
            $error("fill bit exp 0 got %b", d[111]); errors++; end
      endfunction
   endclass

   logic         clock = 0, reset = 1;
   logic         req_tvalid = 0, req_tlast = 0, rsp_tready = 0, csr_valid = 0;
   logic [7:0]   req_tdata = 0;
   logic [1:0]   csr_index = 0;
   logic [31:0]  csr_data = 0;
   logic         req_tready, rsp_tvalid, csr_ready;
   logic [111:0] rsp_tdata;

   line_scoreboard board = new();
   bit  idle_on = 1;      // random idling enabled
   int  hold_cycles = 0;  // requested long receiver hold-off

   relay_command_line_parser_core dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // Hard stop for a hung run.
   initial begin
      #40ms;
      $display("TB_ERROR");
      $finish;
   end

   // Receiver: random stall bursts, one long hold when asked; check results.
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) board.check(rsp_tdata);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 0;
         end else if (stall > 0) begin
            stall--;
            rsp_tready <= 0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 11) - 1;
            rsp_tready <= 0;
         end else rsp_tready <= 1;
      end
   end

   // Send one character word, with an optional idle burst before it.
   // Valid stays high after the word; drop it only for a gap or in drain.
   task automatic send_char(logic [7:0] c, logic lst);
      int gap;
      if (idle_on && $urandom_range(0, 6) == 0) begin
         gap = $urandom_range(1, 11);
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= c;
      req_tlast  <= lst;
      do @(posedge clock); while (!req_tready);
      board.note_char(c, lst);
   endtask

   task automatic send_line(string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   // Wait until the block is idle; lines always give a result, so drain only.
   task automatic drain();
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(csr_type idx, logic [31:0] d);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= d;
      do @(posedge clock); while (!csr_ready);
      board.set_reg(idx, d);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   function automatic string num_text(logic [31:0] v);
      return $sformatf("%0d", v);
   endfunction

   // Pick a space character at random.
   function automatic string blank();
      byte b;
      case ($urandom_range(0, 3))
         0: b = 9;
         1: b = 8'($urandom_range(10, 13));
         default: b = 32;
      endcase
      return string'(b);
   endfunction

   // Random number text, mostly small, sometimes huge or broken.
   function automatic string rand_num();
      case ($urandom_range(0, 9))
         0: return num_text($urandom());
         1: return "99999999999";
         2: return "4294967295";
         3: return "4294967296";
         4: return {num_text($urandom_range(0, 9)), "x"};
         5: return "0";
         default: return num_text($urandom_range(0, 12));
      endcase
   endfunction

   function automatic string rand_keyword();
      string kw [10] = '{"ping", "VERSION", "Status", "allon", "HELP",
                         "reset", "on", "OFF", "pulse", "PINGX"};
      return kw[$urandom_range(0, 9)];
   endfunction

   // Mostly well-formed lines with random arguments; some noise.
   function automatic string rand_line();
      string s, k;
      int n;
      if ($urandom_range(0, 9) == 0) begin
         s = "";
         n = $urandom_range(1, 8);
         for (int i = 0; i < n; i++) s = {s, string'(byte'($urandom_range(1, 255)))};
         return s;
      end
      k = rand_keyword();
      case (k.toupper())
         "RESET": n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : 4;
         "ON":    n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 1;
         "OFF", "PULSE": n = ($urandom_range(0, 4) == 0) ? 3 : $urandom_range(1, 2);
         default: n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : 0;
      endcase
      s = ($urandom_range(0, 3) == 0) ? {blank(), k} : k;
      for (int i = 0; i < n; i++) s = {s, blank(), rand_num()};
      if ($urandom_range(0, 3) == 0) s = {s, blank()};
      return s;
   endfunction

   initial begin
      int sent;
      string line;
      logic [31:0] lo [4] = '{32'd0, 32'd1, 32'd0, 32'hFFFFFFFF};
      logic [31:0] hi [4] = '{32'hFFFFFFFF, 32'd3600, 32'd0, 32'hFFFFFFFF};
      logic [7:0]  rc [4] = '{8'd255, 8'd8, 8'd0, 8'd1};
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: every keyword, extremes and special cases.
      send_line("ping");
      send_line("VERSION");
      send_line("status");
      send_line("allon");
      send_line("help");
      send_line("reset 1 2 3 60");
      send_line("on 8");
      send_line("off 1");
      send_line("pulse 2 3600");
      send_char(8'h00, 1);                     // empty line
      send_line("  ");                         // blanks only
      send_line("on 1 2 3 4 5");               // sixth token
      send_line("on 9");                       // channel out of range
      send_line("off 1 3601");                 // time out of range
      send_line("pulse 1");                    // pulse needs a time
      send_line("reset 0 1 1 1");              // zero session
      send_line("on 4294967296");              // overflow
      send_line("on 1a");                      // non-digit
      send_line("pingpongpingpongping");       // long first token
      // zero byte stops parsing, the rest of the line is ignored
      send_char("p", 0);
      send_char("i", 0);
      send_char("n", 0);
      send_char("g", 0);
      send_char(8'h00, 0);
      send_line("junk");
      send_line({"on", 8'h80, " 1"});          // high byte in keyword
      send_line({"\t", "ON\t", 8'hFF});        // high byte in number
      drain();

      // Random lines across several register settings.
      sent = 0;
      for (int phase = 0; phase < 4; phase++) begin
         write_reg(CSR_RELAY_COUNT, rc[phase]);
         write_reg(CSR_MIN_SECONDS, lo[phase]);
         write_reg(CSR_MAX_SECONDS, hi[phase]);
         write_reg(CSR_DEFAULT_OFF, phase == 2 ? 32'hFFFFFFFF : $urandom());
         if (phase == 1) hold_cycles = 300;    // back up the result queue
         if (phase == 3) idle_on = 0;
         while (sent < (phase + 1) * 450) begin
            line = rand_line();
            send_line(line);
            sent += line.len();
         end
         drain();
      end

      repeat (20) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/rclp_pkg.sv
hdl/rclp_front.sv
hdl/rclp_queue.sv
hdl/rclp_back.sv
hdl/relay_command_line_parser_core.sv
hdl/rclp_checker.sv
bench/relay_command_line_parser_core_test.sv
